>>> sv/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg: shared definitions for the fixed block pool allocator
// Field widths, codes, register defaults and the structs between modules.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  // payload field widths
  localparam int IDX_W  = 12;
  localparam int ST_W   = 2;
  localparam int OFS_W  = 20;

  // configuration registers
  localparam int PBC_W      = 11;
  localparam int REQ_W      = 9;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BLOCK_COUNT      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REQUESTED_BLOCK_BYTES = 1'd1;

  localparam int PBC_RST = 1024;
  localparam int REQ_RST = 8;

  // block size rounding
  localparam int MIN_BLOCK_BYTES = 8;
  localparam int ALIGN_BYTES     = 8;
  localparam int BB_W            = $clog2((1 << REQ_W) + ALIGN_BYTES);

  // effective block count never exceeds what the register can hold
  localparam int EFF_W = PBC_W;

  // link memory
  localparam int LINK_DEPTH = 1 << IDX_W;

  // parameter defaults
  localparam int DEF_MAX_PAGE_BLOCKS = 1024;
  localparam int DEF_MAX_PAGES       = 4;

  // request codes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_UNCARVED  = 2'd2
  } status_t;

  // derived configuration, held in registers
  typedef struct packed {
    logic [EFF_W-1:0] eff_count;
    logic [BB_W-1:0]  block_bytes;
  } cfg_t;

  // one result from the core to the output register
  typedef struct packed {
    logic              valid;
    status_t           status;
    logic [IDX_W-1:0]  granted_index;
    logic [OFS_W-1:0]  byte_offset;
  } result_t;

endpackage

>>> sv/fbpa_ram.sv
// ----------------------------------------------------------------------------
// fbpa_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data registered.
// ----------------------------------------------------------------------------
module fbpa_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> sv/fbpa_cfg.sv
// ----------------------------------------------------------------------------
// fbpa_cfg: configuration registers
// Keeps the clamped block count and the aligned block size, both worked out
// at write time so the datapath sees ready-made values.
// ----------------------------------------------------------------------------
module fbpa_cfg
  import fbpa_pkg::*;
#(
  parameter int MAX_PAGE_BLOCKS = DEF_MAX_PAGE_BLOCKS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  localparam int CMP_W = ($clog2(MAX_PAGE_BLOCKS + 1) > EFF_W) ?
                         $clog2(MAX_PAGE_BLOCKS + 1) : EFF_W;
  localparam logic [EFF_W-1:0] EFF_RST = (PBC_RST > MAX_PAGE_BLOCKS) ?
                                         EFF_W'(MAX_PAGE_BLOCKS) : EFF_W'(PBC_RST);
  localparam logic [BB_W-1:0]  BB_RST  =
    BB_W'((((REQ_RST < MIN_BLOCK_BYTES) ? MIN_BLOCK_BYTES : REQ_RST)
           + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES);

  logic [EFF_W-1:0] eff_r, eff_nxt;
  logic [BB_W-1:0]  bb_r, bb_nxt;
  logic [EFF_W-1:0] cnt_min;
  logic [REQ_W-1:0] req;
  logic [BB_W-1:0]  req_min;
  logic [BB_W-1:0]  req_up;

  // block count: zero acts as one, clamp to the page size
  always_comb begin
    cnt_min = (cfg_wdata[PBC_W-1:0] == '0) ? EFF_W'(1) : cfg_wdata[PBC_W-1:0];
  end

  // block size: at least the minimum, rounded up to the alignment
  always_comb begin
    req     = cfg_wdata[REQ_W-1:0];
    req_min = (req < REQ_W'(MIN_BLOCK_BYTES)) ? BB_W'(MIN_BLOCK_BYTES) : BB_W'(req);
    req_up  = req_min + BB_W'(ALIGN_BYTES - 1);
  end

  always_comb begin
    eff_nxt = eff_r;
    bb_nxt  = bb_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_PAGE_BLOCK_COUNT: begin
          if (CMP_W'(cnt_min) > CMP_W'(MAX_PAGE_BLOCKS)) begin
            eff_nxt = EFF_W'(MAX_PAGE_BLOCKS);
          end else begin
            eff_nxt = cnt_min;
          end
        end
        CFG_REQUESTED_BLOCK_BYTES: begin
          bb_nxt = BB_W'((req_up / ALIGN_BYTES) * ALIGN_BYTES);
        end
        default: begin
          eff_nxt = eff_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_r <= EFF_RST;
      bb_r  <= BB_RST;
    end else begin
      eff_r <= eff_nxt;
      bb_r  <= bb_nxt;
    end
  end

  assign cfg.eff_count   = eff_r;
  assign cfg.block_bytes = bb_r;

endmodule

>>> sv/fbpa_core.sv
// ----------------------------------------------------------------------------
// fbpa_core: free list sequencer
// Holds the list head and page state, drives the link memory, carves pages
// one block per cycle and pops or pushes blocks on the list head.
// ----------------------------------------------------------------------------
module fbpa_core
  import fbpa_pkg::*;
#(
  parameter int MAX_PAGE_BLOCKS = DEF_MAX_PAGE_BLOCKS,
  parameter int MAX_PAGES       = DEF_MAX_PAGES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             req_valid,
  output logic             req_stall,
  input  logic             req_mode,
  input  logic [IDX_W-1:0] req_index,
  output result_t          res,
  input  logic             res_ready
);

  localparam int PG_W   = $clog2(MAX_PAGES + 1);
  localparam int BASE_W = $clog2(MAX_PAGES * MAX_PAGE_BLOCKS + 1);
  localparam int SUM_W  = BASE_W + 1;
  localparam int PROD_W = IDX_W + BB_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_READ  = 5'b00100,
    S_CARVE = 5'b01000,
    S_SCAN  = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    head_r, head_nxt;
  logic                empty_r, empty_nxt;
  logic [PG_W-1:0]     pages_r, pages_nxt;
  logic [BASE_W-1:0]   carve_base_r, carve_base_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [PG_W-1:0]     scan_page_r, scan_page_nxt;
  logic [BASE_W-1:0]   scan_base_r, scan_base_nxt;
  logic [EFF_W-1:0]    carve_cnt_r, carve_cnt_nxt;
  logic [IDX_W-1:0]    carve_idx_r, carve_idx_nxt;

  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [IDX_W-1:0]    wr_data;
  logic [IDX_W-1:0]    rd_data;
  logic [PROD_W-1:0]   product;
  logic [SUM_W-1:0]    page_end;
  logic [IDX_W-1:0]    pos;
  logic                req_xfer;

  // link memory: the read port always looks at the current head
  fbpa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (LINK_DEPTH)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (head_r),
    .rd_data (rd_data)
  );

  assign req_stall = (state_r != S_IDLE);
  assign req_xfer  = req_valid && !req_stall;

  // offset of the block at the head
  assign product  = PROD_W'(head_r) * PROD_W'(cfg.block_bytes);
  // end of the page under test and position of the freed block within it
  assign page_end = SUM_W'(scan_base_r) + SUM_W'(MAX_PAGE_BLOCKS);
  assign pos      = idx_r - IDX_W'(scan_base_r);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    empty_nxt      = empty_r;
    pages_nxt      = pages_r;
    carve_base_nxt = carve_base_r;
    idx_nxt        = idx_r;
    scan_page_nxt  = scan_page_r;
    scan_base_nxt  = scan_base_r;
    carve_cnt_nxt  = carve_cnt_r;
    carve_idx_nxt  = carve_idx_r;
    wr_en          = 1'b0;
    wr_addr        = carve_idx_r;
    wr_data        = carve_idx_r;
    res            = '0;
    res.status     = ST_OK;

    unique case (state_r)
      // take a request; the head read is issued this cycle
      S_IDLE: begin
        if (req_xfer) begin
          idx_nxt       = req_index;
          scan_page_nxt = '0;
          scan_base_nxt = '0;
          state_nxt     = (req_mode == MODE_FREE) ? S_SCAN : S_READ;
        end
      end

      // head was just moved by a carve; let the read catch up
      S_FETCH: begin
        state_nxt = S_READ;
      end

      // allocate: pop the head, carve a page or report exhaustion
      S_READ: begin
        if (empty_r) begin
          if (pages_r == PG_W'(MAX_PAGES)) begin
            res.valid  = 1'b1;
            res.status = ST_EXHAUSTED;
            if (res_ready) begin
              state_nxt = S_IDLE;
            end
          end else begin
            carve_cnt_nxt = '0;
            carve_idx_nxt = IDX_W'(carve_base_r);
            state_nxt     = S_CARVE;
          end
        end else begin
          res.valid         = 1'b1;
          res.granted_index = head_r;
          res.byte_offset   = OFS_W'(product);
          if (res_ready) begin
            if (rd_data == head_r) begin
              empty_nxt = 1'b1;
            end else begin
              head_nxt = rd_data;
            end
            state_nxt = S_IDLE;
          end
        end
      end

      // push one block of the new page per cycle, lowest first
      S_CARVE: begin
        wr_en         = 1'b1;
        wr_addr       = carve_idx_r;
        wr_data       = (carve_cnt_r == '0) ? carve_idx_r : carve_idx_r - IDX_W'(1);
        carve_cnt_nxt = carve_cnt_r + EFF_W'(1);
        carve_idx_nxt = carve_idx_r + IDX_W'(1);
        if (carve_cnt_r == cfg.eff_count - EFF_W'(1)) begin
          head_nxt       = carve_idx_r;
          empty_nxt      = 1'b0;
          pages_nxt      = pages_r + PG_W'(1);
          carve_base_nxt = carve_base_r + BASE_W'(MAX_PAGE_BLOCKS);
          state_nxt      = S_FETCH;
        end
      end

      // free: walk the carved pages until the block's page is found
      S_SCAN: begin
        if (scan_page_r >= pages_r) begin
          res.valid  = 1'b1;
          res.status = ST_UNCARVED;
          if (res_ready) begin
            state_nxt = S_IDLE;
          end
        end else if (SUM_W'(idx_r) < page_end) begin
          res.valid = 1'b1;
          if (IDX_W'(cfg.eff_count) > pos) begin
            res.status = ST_OK;
            if (res_ready) begin
              wr_en     = 1'b1;
              wr_addr   = idx_r;
              wr_data   = empty_r ? idx_r : head_r;
              head_nxt  = idx_r;
              empty_nxt = 1'b0;
            end
          end else begin
            res.status = ST_UNCARVED;
          end
          if (res_ready) begin
            state_nxt = S_IDLE;
          end
        end else begin
          scan_page_nxt = scan_page_r + PG_W'(1);
          scan_base_nxt = scan_base_r + BASE_W'(MAX_PAGE_BLOCKS);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      empty_r      <= 1'b1;
      pages_r      <= '0;
      carve_base_r <= '0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      empty_r      <= empty_nxt;
      pages_r      <= pages_nxt;
      carve_base_r <= carve_base_nxt;
    end
  end

  // per-request working registers
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    scan_page_r <= scan_page_nxt;
    scan_base_r <= scan_base_nxt;
    carve_cnt_r <= carve_cnt_nxt;
    carve_idx_r <= carve_idx_nxt;
  end

endmodule

>>> sv/fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator: fixed-size block pool with a LIFO free list
// Allocate from a non-empty list: head read from the link memory. Allocate
// that carves a page: one link write per block. Free: one step per page
// searched. Results sit in an output register; the next request is taken
// while one waits. Reset is synchronous; the link memory is not cleared.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator
  import fbpa_pkg::*;
#(
  parameter int MAX_PAGE_BLOCKS = DEF_MAX_PAGE_BLOCKS,
  parameter int MAX_PAGES       = DEF_MAX_PAGES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // requests
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_mode,
  input  logic [IDX_W-1:0]      in_block_index,
  // results
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ST_W-1:0]       out_status,
  output logic [IDX_W-1:0]      out_granted_index,
  output logic [OFS_W-1:0]      out_byte_offset
);

  cfg_t             cfg;
  result_t          res;
  logic             out_free;
  logic             out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]  out_status_r;
  logic [IDX_W-1:0] out_granted_index_r;
  logic [OFS_W-1:0] out_byte_offset_r;

  fbpa_cfg #(
    .MAX_PAGE_BLOCKS (MAX_PAGE_BLOCKS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  fbpa_core #(
    .MAX_PAGE_BLOCKS (MAX_PAGE_BLOCKS),
    .MAX_PAGES       (MAX_PAGES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .req_valid (in_valid),
    .req_stall (in_stall),
    .req_mode  (in_mode),
    .req_index (in_block_index),
    .res       (res),
    .res_ready (out_free)
  );

  // output register: free when empty or being transferred this cycle
  assign out_free      = !out_valid_r || !out_stall;
  assign out_valid_nxt = (res.valid && out_free) || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && out_free) begin
      out_status_r        <= res.status;
      out_granted_index_r <= res.granted_index;
      out_byte_offset_r   <= res.byte_offset;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_index = out_granted_index_r;
  assign out_byte_offset   = out_byte_offset_r;

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for fixed_block_pool_allocator
// Directed tests cover single-block pages, size rounding with offset wrap,
// a full-size page, list truncation by a double free and pool exhaustion.
// They are followed by random allocate/free traffic under several register
// settings. Every result is checked against a cycle-free model of the pool;
// sender gaps and receiver stalls are random but for each phase's calm start.
// ----------------------------------------------------------------------------
module tb
  import fbpa_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MAX_BLK        = DEF_MAX_PAGE_BLOCKS;
  localparam int          MAX_PG         = DEF_MAX_PAGES;
  localparam int unsigned WATCHDOG_LIMIT = 12000;
  localparam int          SETTLE_CYCLES  = 6;
  localparam int          TAIL_CYCLES    = 40;
  localparam int          CALM_ITEMS     = 40;

  // one predicted result
  typedef struct {
    status_t          status;
    logic [IDX_W-1:0] grant;
    logic [OFS_W-1:0] offset;
  } grant_rec_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_mode;
  logic [IDX_W-1:0]      in_block_index;
  logic                  out_valid;
  logic                  out_stall;
  logic [ST_W-1:0]       out_status;
  logic [IDX_W-1:0]      out_granted_index;
  logic [OFS_W-1:0]      out_byte_offset;

  // pool model state
  logic [IDX_W-1:0] link_mem [LINK_DEPTH];
  logic [IDX_W-1:0] free_head;
  bit               pool_empty;
  int unsigned      pages_used;
  logic [PBC_W-1:0] blocks_per_page;
  logic [REQ_W-1:0] req_bytes;

  grant_rec_t       owed_grants[$];
  logic [IDX_W-1:0] held_blocks[$];

  bit          tx_calm;
  bit          rx_calm;
  int unsigned err_count;
  int unsigned n_alloc, n_free, n_exhausted, n_uncarved, n_cfg_writes;

  fixed_block_pool_allocator i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_block_index    (in_block_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_granted_index (out_granted_index),
    .out_byte_offset   (out_byte_offset)
  );

  always #5ns clk = ~clk;

  // ---------------------------------------------------------------------------
  // pool model
  // ---------------------------------------------------------------------------
  function automatic int unsigned eff_blocks();
    int unsigned n;
    n = blocks_per_page;
    if (n < 1) n = 1;
    if (n > MAX_BLK) n = MAX_BLK;
    return n;
  endfunction

  function automatic int unsigned block_size();
    int unsigned s;
    s = req_bytes;
    if (s < MIN_BLOCK_BYTES) s = MIN_BLOCK_BYTES;
    return ((s + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  endfunction

  // push the new page's blocks in ascending order
  function automatic void carve_page();
    int unsigned      base;
    logic [IDX_W-1:0] idx;
    base = pages_used * MAX_BLK;
    for (int unsigned i = 0; i < eff_blocks(); i++) begin
      idx = IDX_W'(base + i);
      link_mem[idx] = pool_empty ? idx : free_head;
      free_head = idx;
      pool_empty = 1'b0;
    end
    pages_used++;
  endfunction

  function automatic grant_rec_t pool_predict(logic mode, logic [IDX_W-1:0] idx);
    grant_rec_t       r;
    logic [IDX_W-1:0] g;
    int unsigned      prod;
    r.status = ST_OK;
    r.grant  = '0;
    r.offset = '0;
    if (mode == MODE_ALLOC) begin
      if (pool_empty) begin
        if (pages_used >= MAX_PG) begin
          r.status = ST_EXHAUSTED;
          return r;
        end
        carve_page();
      end
      g = free_head;
      // self link marks the tail
      if (link_mem[g] == g) pool_empty = 1'b1;
      else free_head = link_mem[g];
      prod = g * block_size();
      r.grant  = g;
      r.offset = prod[OFS_W-1:0];
    end else begin
      if ((idx / MAX_BLK) >= pages_used || (idx % MAX_BLK) >= eff_blocks()) begin
        r.status = ST_UNCARVED;
        return r;
      end
      link_mem[idx] = pool_empty ? idx : free_head;
      free_head = idx;
      pool_empty = 1'b0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // idle lengths: mostly short, a few long
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(20, 4);
    return $urandom_range(150, 40);
  endfunction

  function automatic int unsigned tx_gap();
    if (tx_calm || $urandom_range(99) < 55) return 0;
    return pick_gap();
  endfunction

  // receiver stall pattern
  initial begin : stall_gen
    int unsigned hold_n;
    hold_n = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_n > 0) hold_n--;
      else if (!rx_calm && $urandom_range(99) < 25) hold_n = pick_gap();
      out_stall <= (hold_n > 0);
    end
  end

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------
  task automatic send_req(input logic mode, input logic [IDX_W-1:0] idx);
    grant_rec_t  rec;
    int unsigned gap;
    gap = tx_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_block_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // transfer taken at this edge
    rec = pool_predict(mode, idx);
    owed_grants = {owed_grants, rec};
    if (mode == MODE_ALLOC) begin
      n_alloc++;
      if (rec.status == ST_EXHAUSTED) n_exhausted++;
      else held_blocks = {held_blocks, rec.grant};
    end else begin
      n_free++;
      if (rec.status == ST_UNCARVED) begin
        n_uncarved++;
      end else begin
        for (int k = 0; k < held_blocks.size(); k++) begin
          if (held_blocks[k] == idx) begin
            held_blocks.delete(k);
            break;
          end
        end
      end
    end
  endtask

  // hold requests off until every result is back
  task automatic settle_pool(input int unsigned extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed_grants.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_sel, input int unsigned value);
    settle_pool(SETTLE_CYCLES);
    cfg_we    <= 1'b1;
    cfg_index <= reg_sel;
    cfg_wdata <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (reg_sel == CFG_PAGE_BLOCK_COUNT) blocks_per_page = value[PBC_W-1:0];
    else req_bytes = value[REQ_W-1:0];
    n_cfg_writes++;
    repeat (2) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    err_count++;
    if (err_count <= 10)
      $display("[%0t] %s mismatch: expected %0d, got %0d", $realtime, field, want, got);
  endtask

  initial begin : result_check
    grant_rec_t want;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
        if (owed_grants.size() == 0) begin
          err_count++;
          if (err_count <= 10) $display("[%0t] result with nothing pending", $realtime);
        end else begin
          want = owed_grants.pop_front();
          if (out_status !== want.status) flag_mismatch("status", want.status, out_status);
          if (out_granted_index !== want.grant)
            flag_mismatch("granted_index", want.grant, out_granted_index);
          if (out_byte_offset !== want.offset)
            flag_mismatch("byte_offset", want.offset, out_byte_offset);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: cycles without any transfer
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transfer for %0d cycles, %0d results pending",
             quiet, owed_grants.size());
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // count 0 acts as one block per page; default block size
  task automatic test_single_block_pages();
    write_reg(CFG_PAGE_BLOCK_COUNT, 0);
    send_req(MODE_FREE, 12'd0);        // nothing carved yet
    send_req(MODE_ALLOC, 12'd0);       // carves page 0
    send_req(MODE_ALLOC, 12'hFFF);     // list empty again, carves page 1
    send_req(MODE_FREE, 12'd1);        // past the end of a one-block page
    send_req(MODE_FREE, 12'd2048);     // page 2 not carved
    send_req(MODE_FREE, 12'd0);
    send_req(MODE_FREE, 12'd0);        // double free of the lone entry
    send_req(MODE_ALLOC, 12'd0);
  endtask

  // largest request rounds to 512 bytes and the offset wraps
  task automatic test_size_rounding();
    write_reg(CFG_PAGE_BLOCK_COUNT, 3);
    write_reg(CFG_REQUESTED_BLOCK_BYTES, 511);
    send_req(MODE_ALLOC, 12'd0);       // carves page 2
    send_req(MODE_ALLOC, 12'd0);
    send_req(MODE_ALLOC, 12'd0);
    send_req(MODE_FREE, 12'd4095);     // page 3 not carved
    send_req(MODE_FREE, 12'd2051);     // past the current count
    send_req(MODE_FREE, 12'd2049);
    write_reg(CFG_REQUESTED_BLOCK_BYTES, 1);   // raised to the minimum
    send_req(MODE_ALLOC, 12'd0);
  endtask

  // count above the maximum, full page, truncation and exhaustion
  task automatic test_wide_page_exhaustion();
    write_reg(CFG_PAGE_BLOCK_COUNT, 2047);
    write_reg(CFG_REQUESTED_BLOCK_BYTES, 0);
    send_req(MODE_ALLOC, 12'd0);       // carves the last page, 1024 blocks
    send_req(MODE_FREE, 12'd2051);     // now inside the wider count
    send_req(MODE_ALLOC, 12'd0);
    send_req(MODE_ALLOC, 12'd0);
    send_req(MODE_FREE, 12'd4093);     // head freed again: list cut to one
    send_req(MODE_ALLOC, 12'd0);
    send_req(MODE_ALLOC, 12'd0);       // empty and no pages left
    send_req(MODE_FREE, 12'd1024);
    send_req(MODE_ALLOC, 12'd0);
  endtask

  // random allocates and frees; frees mostly of held blocks, some random indices
  task automatic run_traffic_phase(input int unsigned items, input int unsigned alloc_pct,
                                   input int unsigned pbc, input int unsigned req);
    logic [IDX_W-1:0] idx;
    int unsigned      k;
    write_reg(CFG_PAGE_BLOCK_COUNT, pbc);
    write_reg(CFG_REQUESTED_BLOCK_BYTES, req);
    for (int unsigned i = 0; i < items; i++) begin
      tx_calm = (i < CALM_ITEMS);
      rx_calm = (i < CALM_ITEMS);
      if ($urandom_range(99) == 0) settle_pool(0);
      idx = IDX_W'($urandom_range(LINK_DEPTH - 1));
      if ($urandom_range(99) < alloc_pct) begin
        send_req(MODE_ALLOC, idx);
      end else begin
        if (held_blocks.size() != 0 && $urandom_range(99) < 85) begin
          k = $urandom_range(held_blocks.size() - 1);
          idx = held_blocks[k];
        end
        send_req(MODE_FREE, idx);
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  task automatic test_pool_traffic();
    run_traffic_phase(400, 50, MAX_BLK, 256);
    run_traffic_phase(380, 60, $urandom_range(48, 2), $urandom_range(511, 0));
    run_traffic_phase(350, 45, 1, 255);
    run_traffic_phase(400, 55, $urandom_range(2047, MAX_BLK + 1), $urandom_range(16, 9));
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_PAGE_BLOCK_COUNT;
    cfg_wdata      <= '0;
    in_valid       <= 1'b0;
    in_mode        <= MODE_ALLOC;
    in_block_index <= '0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    err_count = 0;
    n_alloc = 0;
    n_free = 0;
    n_exhausted = 0;
    n_uncarved = 0;
    n_cfg_writes = 0;

    // model reset state
    foreach (link_mem[i]) link_mem[i] = '0;
    free_head = '0;
    pool_empty = 1'b1;
    pages_used = 0;
    blocks_per_page = PBC_W'(PBC_RST);
    req_bytes = REQ_W'(REQ_RST);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_single_block_pages();
    test_size_rounding();
    test_wide_page_exhaustion();
    test_pool_traffic();

    settle_pool(TAIL_CYCLES);
    if (owed_grants.size() != 0) begin
      err_count++;
      $display("%0d results never arrived", owed_grants.size());
    end

    $display("Covered %0d allocates (%0d on an exhausted pool) and %0d frees", n_alloc,
             n_exhausted, n_free);
    $display("(%0d of uncarved blocks) across %0d register writes.", n_uncarved,
             n_cfg_writes);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/fbpa_pkg.sv
sv/fbpa_ram.sv
sv/fbpa_cfg.sv
sv/fbpa_core.sv
sv/fixed_block_pool_allocator.sv
verif/tb.sv
